// ===== hdl/dse_pkg.sv =====
// Shared types and codes for the deduplicating stack engine.
`timescale 1ns / 1ps

package dse_pkg;

  localparam int unsigned ValueW = 8;

  // Operation codes of an input item.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ValueW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              was_present;
    logic [ValueW-1:0] top_value;
    logic              is_empty;
  } result_t;

  typedef enum logic {
    S_IDLE,
    S_POP_LOAD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic issue;
    logic pop_commit;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_fetch;
  } sts_t;

endpackage

// ===== hdl/dse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dse_ctrl.sv =====
// Controller state machine of the deduplicating stack engine.
`timescale 1ns / 1ps

module dse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  dse_pkg::sts_t sts_i,
  output dse_pkg::ctl_t ctl_o,
  output logic          busy
);

  dse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dse_pkg::S_IDLE: begin
        if (start && sts_i.needs_fetch) begin
          state_d = dse_pkg::S_POP_LOAD;
        end
      end
      dse_pkg::S_POP_LOAD: begin
        state_d = dse_pkg::S_IDLE;
      end
      default: begin
        state_d = dse_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy  = 1'b0;
    case (state_q)
      dse_pkg::S_IDLE: begin
        ctl_o.issue = start;
      end
      dse_pkg::S_POP_LOAD: begin
        ctl_o.pop_commit = 1'b1;
        busy             = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/dse_datapath.sv =====
// Datapath: depth counter, cached top, presence bits, entry RAM and result register.
`timescale 1ns / 1ps

module dse_datapath #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VALUE_COUNT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dse_pkg::item_t   item_i,
  input  dse_pkg::ctl_t    ctl_i,
  output dse_pkg::sts_t    sts_o,
  output logic             result_valid_o,
  output dse_pkg::result_t result_o
);

  // Only values below 256 can arrive, so only that many keys can ever be held.
  localparam int unsigned KeyCount = (VALUE_COUNT < 256) ? VALUE_COUNT : 256;
  localparam int unsigned KeyW     = (KeyCount > 1) ? $clog2(KeyCount) : 1;
  localparam int unsigned AddrW    = $clog2(STACK_DEPTH);
  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LutSize  = 2 ** dse_pkg::ValueW;

  logic [KeyW-1:0]     key_lut [LutSize];
  logic [KeyW-1:0]     key;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     count_m2;
  logic [KeyW-1:0]     top_q, top_d;
  logic [KeyCount-1:0] present_q, present_d;
  logic                res_valid_q, res_valid_d;
  dse_pkg::result_t    res_q, res_d;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [AddrW-1:0]    ram_raddr;
  logic [KeyW-1:0]     ram_rdata;

  // Reduction of an input value to its key, worked out at elaboration.
  for (genvar g = 0; g < LutSize; g++) begin : g_key_lut
    assign key_lut[g] = KeyW'(g % VALUE_COUNT);
  end

  assign key       = key_lut[item_i.value];
  assign count_m2  = count_q - CntW'(2);
  assign ram_raddr = count_m2[AddrW-1:0];
  assign ram_waddr = count_q[AddrW-1:0];

  assign sts_o.needs_fetch = (item_i.op == dse_pkg::OP_POP) && (count_q != '0);

  dse_ram #(
    .WIDTH (KeyW),
    .DEPTH (STACK_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d     = count_q;
    top_d       = top_q;
    present_d   = present_q;
    ram_we      = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (ctl_i.issue) begin
      res_d.status      = dse_pkg::STAT_OK;
      res_d.was_present = 1'b0;
      case (item_i.op)
        dse_pkg::OP_PUSH: begin
          res_valid_d = 1'b1;
          if (present_q[key]) begin
            res_d.was_present = 1'b1;
          end else if (count_q == CntW'(STACK_DEPTH)) begin
            res_d.status = dse_pkg::STAT_FULL;
          end else begin
            ram_we         = 1'b1;
            count_d        = count_q + CntW'(1);
            present_d[key] = 1'b1;
            top_d          = key;
          end
        end
        dse_pkg::OP_POP: begin
          // A pop on a held entry finishes once the entry below is read.
          if (count_q == '0) begin
            res_valid_d  = 1'b1;
            res_d.status = dse_pkg::STAT_EMPTY;
          end
        end
        default: begin
          res_valid_d = 1'b1;
          if (count_q == '0) begin
            res_d.status = dse_pkg::STAT_EMPTY;
          end
        end
      endcase
    end

    if (ctl_i.pop_commit) begin
      present_d[top_q]  = 1'b0;
      count_d           = count_q - CntW'(1);
      top_d             = (count_q == CntW'(1)) ? '0 : ram_rdata;
      res_valid_d       = 1'b1;
      res_d.status      = dse_pkg::STAT_OK;
      res_d.was_present = 1'b0;
    end

    res_d.top_value = dse_pkg::ValueW'(top_d);
    res_d.is_empty  = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_q       <= '0;
      present_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      top_q       <= top_d;
      present_q   <= present_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== hdl/dedup_stack_engine_core.sv =====
// Top level of the deduplicating stack engine.
`timescale 1ns / 1ps

// A LIFO stack that never holds the same value twice.
// Command channel: an operation transfer happens at a rising edge where start
// is high and busy is low; cmd_i carries the op code and the value to push.
// Result channel: each operation yields exactly one result, shown on result_o
// for one cycle with result_valid_o high. The receiver cannot stall, so every
// result must be taken in the cycle it appears.
// Push, query and pop on an empty stack give their registered result in the
// cycle after the transfer, and a new operation may follow in the next cycle.
// A pop on a non-empty stack holds busy high for one cycle while the new top
// entry is read from the entry RAM, whose read data is registered; its result
// then passes through the result register.
// Sustained rate: one operation per cycle while busy is low.
// Reset (rst_ni low, asynchronous) empties the stack, clears all presence
// bits and drops any pending result; the entry RAM is not cleared because
// only entries below the depth count are ever read.
module dedup_stack_engine_core #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VALUE_COUNT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  dse_pkg::item_t   cmd_i,
  output logic             result_valid_o,
  output dse_pkg::result_t result_o
);

  dse_pkg::ctl_t ctl;
  dse_pkg::sts_t sts;

  // The controller issues each operation and sequences the pop fetch; stack state lives in the datapath.
  dse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  dse_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_COUNT (VALUE_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (cmd_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== hdl/dse_checker.sv =====
// Port-level assertions for the deduplicating stack engine, bound to the top level.
`timescale 1ns / 1ps

module dse_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input dse_pkg::item_t   cmd_i,
  input logic             result_valid_o,
  input dse_pkg::result_t result_o
);

  // Every transfer is answered next cycle or parks the engine for a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (result_valid_o || busy))
    else $error("transfer produced neither a result nor a busy cycle");

  // After a pop fetch busy is low again and a result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && result_valid_o))
    else $error("pop fetch did not complete in one cycle");

  // A result only follows a transfer or a pop fetch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start && !busy) && !$past(busy)) |-> !result_valid_o)
    else $error("result without a pending operation");

  // An empty stack reports a zero top value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.is_empty) |-> (result_o.top_value == '0))
    else $error("empty stack reported a nonzero top");

  // A duplicate push is always a success and leaves a non-empty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.was_present) |->
      (result_o.status == dse_pkg::STAT_OK && !result_o.is_empty))
    else $error("duplicate push reported inconsistently");

endmodule

bind dedup_stack_engine_core dse_checker u_dse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
